// ----- src/mmm01_pkg.sv -----
package mmm01_pkg;

  localparam int ROM_AW   = 23;
  localparam int CFG_IW   = 4;
  localparam int CFG_DW   = 5;

  localparam logic [CFG_IW-1:0] CFG_ROM_SIZE = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_RAM_SIZE = CFG_IW'(1);

  localparam logic [2:0] ACT_ROM_LO = 3'd0;
  localparam logic [2:0] ACT_ROM_HI = 3'd1;
  localparam logic [2:0] ACT_RAM_RD = 3'd2;
  localparam logic [2:0] ACT_RAM_WR = 3'd3;
  localparam logic [2:0] ACT_REG_WR = 3'd4;

  localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
  localparam logic [4:0]  ROM_LOG2_MIN = 5'd15;
  localparam logic [3:0]  RAM_LOG2_MIN = 4'd11;
  localparam logic [15:0] ADDR_BANK    = 16'h2000;
  localparam logic [15:0] ADDR_RAMBANK = 16'h4000;
  localparam logic [15:0] ADDR_IGNORE  = 16'h6000;
  localparam logic [7:0]  RD_DISABLED  = 8'hFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [ROM_AW-1:0] rom_address;
    logic              rom_fetch;
    logic [7:0]        read_data;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_req_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_OFF,
    RD_MEM
  } rd_sel_t;

endpackage

// ----- src/mmm01_ram.sv -----
module mmm01_ram #(
  parameter int RAM_BYTES = 32768,
  localparam int AW = $clog2(RAM_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mmm01_pkg::ram_req_t req,
  input  logic [AW-1:0]      addr,
  input  logic [7:0]         wdata,
  output logic [7:0]         rdata,
  output logic               busy
);
  import mmm01_pkg::*;

  logic [7:0]    mem [RAM_BYTES];
  logic [7:0]    rdata_r;
  logic          busy_r, busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // clearing pass after reset: zeroes each byte in address order, then clears busy
  always_comb begin
    busy_nxt     = busy_r;
    clr_addr_nxt = clr_addr_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(RAM_BYTES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 8'h00;
    end else if (req.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

// ----- src/mmm01_bank_mapper.sv -----
// Results are registered: a request accepted in one cycle shows its result in the next.
// Throughput: one request per cycle while in_stall is low; the output register holds while out_stall is high.
// Reset (rst_n low, synchronous) clears the mapper registers, sets both size registers
// to 15 and starts a clearing pass that zeroes every byte of the external RAM, during
// which in_stall stays high; configuration writes are taken throughout.
module mmm01_bank_mapper #(
  parameter int RAM_BYTES     = 32768,
  parameter int ROM_ADDR_BITS = 23
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mmm01_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mmm01_pkg::out_item_t            out_data,
  input  logic                            cfg_we,
  input  logic [mmm01_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mmm01_pkg::CFG_DW-1:0]    cfg_wdata
);
  import mmm01_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [4:0] ROM_LOG2_MAX = 5'(ROM_ADDR_BITS);

  logic [4:0] cfg_rom_r, cfg_rom_nxt;
  logic [3:0] cfg_ram_r, cfg_ram_nxt;
  logic       mapped_r, mapped_nxt;
  logic [7:0] ram_en_r, ram_en_nxt;
  logic [5:0] base_r, base_nxt;
  logic [7:0] sel_r, sel_nxt;
  logic [7:0] rbank_r, rbank_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ROM_AW-1:0] rom_addr_r, rom_addr_nxt;
  logic              fetch_r, fetch_nxt;
  rd_sel_t           rd_sel_r, rd_sel_nxt;

  logic          accept, ram_on, ram_busy;
  logic [4:0]    rom_l;
  logic [3:0]    ram_l;
  logic [23:0]   rom_span;
  logic [24:0]   rom_sum;
  logic [20:0]   ram_sum, ram_mask;
  logic [AW-1:0] ram_idx;
  logic [7:0]    ram_q;
  ram_req_t      ram_req;

  assign in_stall = ram_busy || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign ram_on   = (ram_en_r[3:0] == RAM_EN_KEY);

  // effective sizes
  always_comb begin
    rom_l = cfg_rom_r;
    if (rom_l < ROM_LOG2_MIN) rom_l = ROM_LOG2_MIN;
    if (rom_l > ROM_LOG2_MAX) rom_l = ROM_LOG2_MAX;
    ram_l = (cfg_ram_r < RAM_LOG2_MIN) ? RAM_LOG2_MIN : cfg_ram_r;
  end

  assign rom_span = 24'(1) << rom_l;
  assign ram_sum  = {rbank_r, 13'b0} + {8'b0, in_data.bus_address[12:0]};
  assign ram_mask = (21'(1) << ram_l) - 21'(1);
  assign ram_idx  = AW'(ram_sum & ram_mask);

  always_comb begin
    if (!mapped_r) begin
      // unmapped: both windows see the last 32 KiB
      rom_sum = 25'(in_data.bus_address) + 25'(rom_span) - 25'(32'h8000);
    end else if (in_data.action == ACT_ROM_LO) begin
      rom_sum = 25'(in_data.bus_address) + 25'({base_r, 14'b0});
    end else begin
      rom_sum = 25'(in_data.bus_address[13:0]) + 25'({base_r, 14'b0})
              + 25'({sel_r, 14'b0});
    end
  end

  always_comb begin
    cfg_rom_nxt = cfg_rom_r;
    cfg_ram_nxt = cfg_ram_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE: cfg_rom_nxt = cfg_wdata;
        CFG_RAM_SIZE: cfg_ram_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mapped_nxt    = mapped_r;
    ram_en_nxt    = ram_en_r;
    base_nxt      = base_r;
    sel_nxt       = sel_r;
    rbank_nxt     = rbank_r;
    out_valid_nxt = out_valid_r && out_stall;
    rom_addr_nxt  = rom_addr_r;
    fetch_nxt     = fetch_r;
    rd_sel_nxt    = rd_sel_r;
    ram_req       = '0;
    if (accept) begin
      out_valid_nxt = 1'b1;
      rom_addr_nxt  = '0;
      fetch_nxt     = 1'b0;
      rd_sel_nxt    = RD_ZERO;
      case (in_data.action)
        ACT_ROM_LO, ACT_ROM_HI: begin
          rom_addr_nxt = ROM_AW'(rom_sum & (25'(rom_span) - 25'(1)));
          fetch_nxt    = 1'b1;
        end
        ACT_RAM_RD: begin
          rd_sel_nxt = ram_on ? RD_MEM : RD_OFF;
          ram_req.re = ram_on;
        end
        ACT_RAM_WR: begin
          ram_req.we = ram_on;
        end
        ACT_REG_WR: begin
          if (in_data.bus_address < ADDR_BANK) begin
            if (!mapped_r) mapped_nxt = 1'b1;
            else           ram_en_nxt = in_data.write_data;
          end else if (in_data.bus_address < ADDR_RAMBANK) begin
            if (!mapped_r) base_nxt = in_data.write_data[5:0];
            else           sel_nxt  = in_data.write_data;
          end else if (in_data.bus_address < ADDR_IGNORE) begin
            if (mapped_r) rbank_nxt = in_data.write_data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rom_r   <= ROM_LOG2_MIN;
      cfg_ram_r   <= 4'd15;
      mapped_r    <= 1'b0;
      ram_en_r    <= '0;
      base_r      <= '0;
      sel_r       <= '0;
      rbank_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_rom_r   <= cfg_rom_nxt;
      cfg_ram_r   <= cfg_ram_nxt;
      mapped_r    <= mapped_nxt;
      ram_en_r    <= ram_en_nxt;
      base_r      <= base_nxt;
      sel_r       <= sel_nxt;
      rbank_r     <= rbank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rom_addr_r <= rom_addr_nxt;
    fetch_r    <= fetch_nxt;
    rd_sel_r   <= rd_sel_nxt;
  end

  mmm01_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .addr  (ram_idx),
    .wdata (in_data.write_data),
    .rdata (ram_q),
    .busy  (ram_busy)
  );

  always_comb begin
    out_data.rom_address = rom_addr_r;
    out_data.rom_fetch   = fetch_r;
    case (rd_sel_r)
      RD_MEM:  out_data.read_data = ram_q;
      RD_OFF:  out_data.read_data = RD_DISABLED;
      default: out_data.read_data = 8'h00;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/mmm01_checker.sv -----
module mmm01_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input mmm01_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input mmm01_pkg::out_item_t out_data
);
  import mmm01_pkg::*;

  logic in_acc;
  logic is_rom;

  assign in_acc = in_valid && !in_stall;
  assign is_rom = (in_data.action == ACT_ROM_LO) || (in_data.action == ACT_ROM_HI);

  // clearing pass holds off requests straight after reset
  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("requests taken during RAM clearing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_rom_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_rom |=> out_valid && out_data.rom_fetch && out_data.read_data == 8'h00)
    else $error("ROM read without fetch result");

  a_other_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_rom |=> out_valid && !out_data.rom_fetch && out_data.rom_address == '0)
    else $error("non-ROM request produced a ROM address");

endmodule

bind mmm01_bank_mapper mmm01_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
